/* rtl/dlasr_pkg.sv */
package dlasr_pkg;

    localparam int NUM_CHANNELS_DEF = 8;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam int CODE_W  = 16;
    localparam int VOLTS_W = 15;
    localparam int RANGE_W = 14;
    localparam int PULSE_W = 16;
    localparam int HALF_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_MV       = 2'd0,
        CFG_PULSE_TICKS    = 2'd1,
        CFG_SCK_HALF_TICKS = 2'd2,
        CFG_UNUSED         = 2'd3
    } cfg_idx_t;

    localparam logic [RANGE_W-1:0] RANGE_MV_RST       = 14'd10000;
    localparam logic [PULSE_W-1:0] PULSE_TICKS_RST    = 16'd100;
    localparam logic [HALF_W-1:0]  SCK_HALF_TICKS_RST = 8'd1;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mv;
        logic [PULSE_W-1:0] pulse_ticks;
        logic [HALF_W-1:0]  sck_half_ticks;
    } cfg_t;

    typedef struct packed {
        logic start_req;
        logic busy_req;
        logic dout_a;
        logic dout_b;
    } item_t;

    // one tick's pin drive and word report, before scaling
    typedef struct packed {
        logic                     cnvst_n;
        logic                     cs_n;
        logic                     sck;
        logic                     word_valid;
        logic [1:0]               word_index;
        logic                     last_word;
        logic                     frame_done;
        logic signed [CODE_W-1:0] code_a;
        logic signed [CODE_W-1:0] code_b;
    } step_t;

    typedef struct packed {
        step_t                     step;
        logic signed [VOLTS_W-1:0] volts_a;
        logic signed [VOLTS_W-1:0] volts_b;
    } result_t;

endpackage

/* rtl/dlasr_seq.sv */
module dlasr_seq #(
    parameter int NUM_CHANNELS = dlasr_pkg::NUM_CHANNELS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  dlasr_pkg::cfg_t  cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  dlasr_pkg::item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output dlasr_pkg::step_t out_step
);
    import dlasr_pkg::*;

    localparam int WORDS  = (NUM_CHANNELS / 2 == 0) ? 1 : NUM_CHANNELS / 2;
    localparam int WC_RAW = $clog2(WORDS + 1);
    localparam int WC_W   = (WC_RAW < 2) ? 2 : WC_RAW;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_CNVLOW = 3'd1,
        PH_SETTLE = 3'd2,
        PH_WAIT   = 3'd3,
        PH_SCKLO  = 3'd4,
        PH_SCKHI  = 3'd5
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [PULSE_W-1:0] tick_reg, tick_next;
    logic [4:0]         bit_reg, bit_next;
    logic [WC_W-1:0]    word_reg, word_next;
    logic [CODE_W-1:0]  shift_a_reg, shift_a_next;
    logic [CODE_W-1:0]  shift_b_reg, shift_b_next;
    logic               done_reg, done_next;
    logic               valid_reg;
    step_t              step_reg, step_next;

    logic [PULSE_W-1:0] plim;
    logic [HALF_W-1:0]  hlim;
    logic [PULSE_W:0]   tick_sum;
    logic [4:0]         bit_sum;
    logic [WC_W:0]      word_sum;
    logic [CODE_W-1:0]  sa_in, sb_in;
    logic               take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_step  = step_reg;

    assign plim     = (cfg.pulse_ticks == '0) ? PULSE_W'(1) : cfg.pulse_ticks;
    assign hlim     = (cfg.sck_half_ticks == '0) ? HALF_W'(1) : cfg.sck_half_ticks;
    assign tick_sum = {1'b0, tick_reg} + (PULSE_W+1)'(1);
    assign bit_sum  = bit_reg + 5'd1;
    assign word_sum = {1'b0, word_reg} + (WC_W+1)'(1);
    assign sa_in    = {shift_a_reg[CODE_W-2:0], in_item.dout_a};
    assign sb_in    = {shift_b_reg[CODE_W-2:0], in_item.dout_b};

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        word_next    = word_reg;
        shift_a_next = shift_a_reg;
        shift_b_next = shift_b_reg;
        done_next    = done_reg;
        step_next    = '0;
        step_next.cnvst_n = 1'b1;
        step_next.cs_n    = 1'b1;
        step_next.sck     = 1'b1;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_item.start_req)
                begin
                    phase_next = PH_CNVLOW;
                    tick_next  = '0;
                end
            end
            PH_CNVLOW:
            begin
                step_next.cnvst_n = 1'b0;
                if (tick_sum >= {1'b0, plim})
                begin
                    tick_next  = '0;
                    phase_next = PH_SETTLE;
                end
                else
                begin
                    tick_next = tick_sum[PULSE_W-1:0];
                end
            end
            PH_SETTLE:
            begin
                if (tick_sum >= {1'b0, plim})
                begin
                    tick_next  = '0;
                    phase_next = PH_WAIT;
                end
                else
                begin
                    tick_next = tick_sum[PULSE_W-1:0];
                end
            end
            PH_WAIT:
            begin
                if (!in_item.busy_req)
                begin
                    phase_next   = PH_SCKLO;
                    tick_next    = '0;
                    bit_next     = '0;
                    word_next    = '0;
                    shift_a_next = '0;
                    shift_b_next = '0;
                end
            end
            PH_SCKLO:
            begin
                step_next.cs_n = 1'b0;
                step_next.sck  = 1'b0;
                if (tick_sum >= (PULSE_W+1)'(hlim))
                begin
                    tick_next  = '0;
                    phase_next = PH_SCKHI;
                    if (bit_sum >= 5'd16)
                    begin
                        bit_next             = '0;
                        step_next.word_valid = 1'b1;
                        step_next.word_index = word_reg[1:0];
                        step_next.last_word  = (word_sum >= (WC_W+1)'(WORDS));
                        step_next.code_a     = $signed(sa_in);
                        step_next.code_b     = $signed(sb_in);
                        word_next            = word_sum[WC_W-1:0];
                        shift_a_next         = '0;
                        shift_b_next         = '0;
                    end
                    else
                    begin
                        bit_next     = bit_sum;
                        shift_a_next = sa_in;
                        shift_b_next = sb_in;
                    end
                end
                else
                begin
                    tick_next = tick_sum[PULSE_W-1:0];
                end
            end
            PH_SCKHI:
            begin
                step_next.cs_n = 1'b0;
                if (tick_sum >= (PULSE_W+1)'(hlim))
                begin
                    tick_next = '0;
                    if (bit_reg == '0 && word_reg >= WC_W'(WORDS))
                    begin
                        phase_next = PH_IDLE;
                        word_next  = '0;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SCKLO;
                    end
                end
                else
                begin
                    tick_next = tick_sum[PULSE_W-1:0];
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
            end
        endcase

        step_next.frame_done = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_reg     <= '0;
            word_reg    <= '0;
            shift_a_reg <= '0;
            shift_b_reg <= '0;
            done_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            if (take)
            begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                bit_reg     <= bit_next;
                word_reg    <= word_next;
                shift_a_reg <= shift_a_next;
                shift_b_reg <= shift_b_next;
                done_reg    <= done_next;
                step_reg    <= step_next;
                valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/dlasr_scale.sv */
module dlasr_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dlasr_pkg::RANGE_W-1:0]       range_mv,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  dlasr_pkg::step_t                    in_step,
    output logic                                out_valid,
    input  logic                                out_ready,
    output dlasr_pkg::result_t                  out_result
);
    import dlasr_pkg::*;

    localparam int PROD_W = CODE_W + RANGE_W + 1;

    logic signed [PROD_W-1:0] prod_a, prod_b;
    logic signed [RANGE_W:0]  range_s;
    logic                     valid_reg;
    result_t                  result_reg;

    assign range_s = $signed({1'b0, range_mv});
    assign prod_a  = in_step.code_a * range_s;
    assign prod_b  = in_step.code_b * range_s;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                valid_reg          <= 1'b1;
                result_reg.step    <= in_step;
                // floor(p / 2^15), kept to 15 bits
                result_reg.volts_a <= prod_a[VOLTS_W+14:15];
                result_reg.volts_b <= prod_b[VOLTS_W+14:15];
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/dual_line_adc_serial_readout.sv */
// channel  dir  handshake               payload
// s_       in   s_tvalid / s_tready     s_tdata: one pin sample word per tick
// m_       out  m_tvalid / m_tready     m_tdata, m_tuser (word_valid), m_tlast (last_word)
// cfg_     in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One result word per input word, one word per cycle sustained while m_tready stays high.
// Registered stages, in order: input register, sequencer step, scaling multiply.
// rst_n clears the config to defaults and the sequencer to idle.
// A stall on m_ tready backs up through each stage; s_tready drops only when all are full.
// cfg_ready is always high; writes land at once.
module dual_line_adc_serial_readout #(
    parameter int NUM_CHANNELS = dlasr_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] start_req, [1] busy_req, [2] dout_a, [3] dout_b
    input  logic [dlasr_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] cnvst_n, [1] cs_n, [2] sck, [4:3] word_index, [20:5] code_a,
    // [36:21] code_b, [51:37] volts_a, [66:52] volts_b, [67] frame_done
    output logic [dlasr_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // [0] word_valid
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dlasr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dlasr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dlasr_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    seq_in_ready;
    logic    seq_valid;
    logic    scale_ready;
    step_t   seq_step;
    result_t res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || seq_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_mv       <= RANGE_MV_RST;
            cfg_reg.pulse_ticks    <= PULSE_TICKS_RST;
            cfg_reg.sck_half_ticks <= SCK_HALF_TICKS_RST;
            in_valid_reg           <= 1'b0;
            in_item_reg            <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_RANGE_MV:       cfg_reg.range_mv       <= cfg_data[RANGE_W-1:0];
                    CFG_PULSE_TICKS:    cfg_reg.pulse_ticks    <= cfg_data[PULSE_W-1:0];
                    CFG_SCK_HALF_TICKS: cfg_reg.sck_half_ticks <= cfg_data[HALF_W-1:0];
                    default:            ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg          <= 1'b1;
                in_item_reg.start_req <= s_tdata[0];
                in_item_reg.busy_req  <= s_tdata[1];
                in_item_reg.dout_a    <= s_tdata[2];
                in_item_reg.dout_b    <= s_tdata[3];
            end
            else if (seq_in_ready)
            begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    dlasr_seq #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid_reg),
        .in_ready  (seq_in_ready),
        .in_item   (in_item_reg),
        .out_valid (seq_valid),
        .out_ready (scale_ready),
        .out_step  (seq_step)
    );

    dlasr_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .range_mv   (cfg_reg.range_mv),
        .in_valid   (seq_valid),
        .in_ready   (scale_ready),
        .in_step    (seq_step),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (res)
    );

    assign m_tdata = {
        4'b0000,
        res.step.frame_done,
        res.volts_b,
        res.volts_a,
        res.step.code_b,
        res.step.code_a,
        res.step.word_index,
        res.step.sck,
        res.step.cs_n,
        res.step.cnvst_n
    };
    assign m_tuser = res.step.word_valid;
    assign m_tlast = res.step.last_word;

endmodule

/* rtl/dlasr_checker.sv */
module dlasr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [dlasr_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [0:0]                        m_tuser,
    input logic                              m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed while stalled");

    // no word completed: index, codes and millivolts are all zero
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[66:3] == '0 && !m_tlast)
        else $error("payload set without word_valid");

    // words complete only on the last tick of a low serial-clock phase
    a_word_phase: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> !m_tdata[1] && !m_tdata[2] && m_tdata[0])
        else $error("word reported outside a low clock phase");

    a_pins: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[1] && m_tdata[2])
        else $error("chip select or clock active during convert pulse");

    a_sck_cs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> !m_tdata[1])
        else $error("serial clock low without chip select");

endmodule

bind dual_line_adc_serial_readout dlasr_checker u_dlasr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
